FILE: src/rbpl_pkg.sv
// Shared types and constants for the rectangle BSP point lookup block.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rbpl_pkg;

  localparam int CMD_BITS    = 2;
  localparam int IDX_BITS    = 11;
  localparam int KIND_BITS   = 2;
  localparam int LINK2_BITS  = 12;
  localparam int RECT_BITS   = 10;
  localparam int PTR_BITS    = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  localparam logic [CMD_BITS-1:0] CMD_NODE_WR = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ITEM_WR = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd2;

  localparam logic [KIND_BITS-1:0] KIND_SPLIT_X = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SPLIT_Y = 2'd1;

  typedef enum logic [1:0] {
    OP_NODE_WR,
    OP_ITEM_WR,
    OP_QUERY,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [IDX_BITS-1:0]   idx;
    logic [KIND_BITS-1:0]  kind;
    logic [IDX_BITS-1:0]   first;
    logic [LINK2_BITS-1:0] second;
    logic [RECT_BITS-1:0]  rect;
  } cmd_t;

  typedef struct packed {
    logic                 is_answer;
    logic                 found;
    logic [RECT_BITS-1:0] rect;
    logic                 walk_fault;
  } res_t;

  localparam res_t RES_ACK = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_EVAL,
    ST_ITEM_RD,
    ST_ITEM_EVAL,
    ST_REPLY
  } state_t;

endpackage

`default_nettype wire

FILE: src/rbpl_front.sv
// Front end: accepts input transactions, classifies them and holds them in a
// two-entry command queue for the back end. Depends on rbpl_pkg.
`default_nettype none

module rbpl_front #(
  parameter int NODE_DEPTH = 1024,
  parameter int ITEM_DEPTH = 2048,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rbpl_pkg::CMD_BITS-1:0]       in_command,
  input  wire logic [rbpl_pkg::IDX_BITS-1:0]       in_entry_index,
  input  wire logic [rbpl_pkg::KIND_BITS-1:0]      in_node_kind,
  input  wire logic [rbpl_pkg::IDX_BITS-1:0]       in_first_link,
  input  wire logic [rbpl_pkg::LINK2_BITS-1:0]     in_second_link,
  input  wire logic [rbpl_pkg::RECT_BITS-1:0]      in_rect_id,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_left,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_top,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_right,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_bottom,
  output logic                                     q_valid,
  output rbpl_pkg::cmd_t                           q_cmd,
  output logic [3:0][COORD_BITS-1:0]               q_coord,
  input  wire logic                                q_pop
);
  import rbpl_pkg::*;

  cmd_t                        entry_mem_r [QUEUE_DEPTH];
  logic [3:0][COORD_BITS-1:0]  coord_mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]          count_r, count_nxt;
  logic                        push;
  cmd_t                        cls;

  // Writes beyond a table are turned into no-operations here.
  always_comb begin
    cls.idx    = in_entry_index;
    cls.kind   = in_node_kind;
    cls.first  = in_first_link;
    cls.second = in_second_link;
    cls.rect   = in_rect_id;
    cls.op     = OP_NOP;
    unique case (in_command)
      CMD_NODE_WR: begin
        if (32'(in_entry_index) < NODE_DEPTH) cls.op = OP_NODE_WR;
      end
      CMD_ITEM_WR: begin
        if (32'(in_entry_index) < ITEM_DEPTH) cls.op = OP_ITEM_WR;
      end
      CMD_QUERY: begin
        cls.op = OP_QUERY;
      end
      default: begin
        cls.op = OP_NOP;
      end
    endcase
  end

  assign in_stall = (count_r == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = entry_mem_r[rd_ptr_r];
  assign q_coord  = coord_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + (QPTR_BITS + 1)'(1);
      2'b01:   count_nxt = count_r - (QPTR_BITS + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slice 0 holds the left edge, 1 the top, 2 the right and 3 the bottom.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_mem_r[wr_ptr_r] <= cls;
      coord_mem_r[wr_ptr_r] <= {in_coord_bottom, in_coord_right, in_coord_top, in_coord_left};
    end
  end

endmodule

`default_nettype wire

FILE: src/rbpl_back.sv
// Back end: owns the node and item memories, performs table writes, walks
// the tree for queries, scans leaves and holds the result register.
// Depends on rbpl_pkg.
`default_nettype none

module rbpl_back #(
  parameter int NODE_DEPTH = 1024,
  parameter int ITEM_DEPTH = 2048,
  parameter int COORD_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire rbpl_pkg::cmd_t                   q_cmd,
  input  wire logic [3:0][COORD_BITS-1:0]       q_coord,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_is_answer,
  output logic                                  out_found,
  output logic [rbpl_pkg::RECT_BITS-1:0]        out_found_rect,
  output logic                                  out_walk_fault
);
  import rbpl_pkg::*;

  localparam int NA     = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int IA     = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int NODE_W = KIND_BITS + IDX_BITS + LINK2_BITS + COORD_BITS;
  localparam int ITEM_W = RECT_BITS + 4 * COORD_BITS;

  logic [NODE_W-1:0] node_mem [NODE_DEPTH];
  logic [ITEM_W-1:0] item_mem [ITEM_DEPTH];
  logic [NODE_W-1:0] node_q;
  logic [ITEM_W-1:0] item_q;

  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  res_t                     out_res_r;
  res_t                     res_r;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic [NA-1:0]            cur_r, visits_r;
  logic [PTR_BITS-1:0]      ptr_r, end_r;

  logic                     slot_free;
  logic                     node_we, item_we, out_load;
  res_t                     out_res;
  logic [31:0]              idx_ext, ptr_ext, next_ext;
  logic [NA-1:0]            node_waddr, next_addr;
  logic [IA-1:0]            item_waddr, item_raddr;

  logic [KIND_BITS-1:0]     nd_kind;
  logic [IDX_BITS-1:0]      nd_first;
  logic [LINK2_BITS-1:0]    nd_second;
  logic signed [COORD_BITS-1:0] nd_bound, coord_sel;
  logic                     is_split, link_bad, long_walk;
  logic [LINK2_BITS-1:0]    next_link;

  logic [RECT_BITS-1:0]     it_owner;
  logic signed [COORD_BITS-1:0] it_l, it_t, it_r, it_b;
  logic                     hit, item_ok;

  assign slot_free = !out_valid_r || !out_stall;

  assign idx_ext    = 32'(q_cmd.idx);
  assign node_waddr = idx_ext[NA-1:0];
  assign item_waddr = idx_ext[IA-1:0];
  assign ptr_ext    = 32'(ptr_r);
  assign item_raddr = ptr_ext[IA-1:0];

  assign {nd_kind, nd_first, nd_second, nd_bound} = node_q;
  assign {it_owner, it_l, it_t, it_r, it_b}       = item_q;

  assign is_split  = (nd_kind == KIND_SPLIT_X) || (nd_kind == KIND_SPLIT_Y);
  assign coord_sel = (nd_kind == KIND_SPLIT_X) ? x_r : y_r;
  assign next_link = (coord_sel < nd_bound) ? {1'b0, nd_first} : nd_second;
  assign next_ext  = 32'(next_link);
  assign next_addr = next_ext[NA-1:0];
  assign link_bad  = (next_ext >= NODE_DEPTH);
  assign long_walk = (visits_r == NA'(NODE_DEPTH - 1));

  assign item_ok = (ptr_r < end_r) && (ptr_ext < ITEM_DEPTH);
  assign hit     = (it_l <= x_r) && (it_t <= y_r) && (it_r >= x_r) && (it_b >= y_r);

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= {q_cmd.kind, q_cmd.first, q_cmd.second, q_coord[0]};
    node_q <= node_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_waddr] <= {q_cmd.rect, q_coord[0], q_coord[1], q_coord[2], q_coord[3]};
    end
    item_q <= item_mem[item_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free && (q_cmd.op == OP_QUERY)) state_nxt = ST_NODE_RD;
      end
      ST_NODE_RD: begin
        state_nxt = ST_NODE_EVAL;
      end
      ST_NODE_EVAL: begin
        if (!is_split)                  state_nxt = ST_ITEM_RD;
        else if (link_bad || long_walk) state_nxt = ST_REPLY;
        else                            state_nxt = ST_NODE_RD;
      end
      ST_ITEM_RD: begin
        state_nxt = item_ok ? ST_ITEM_EVAL : ST_REPLY;
      end
      ST_ITEM_EVAL: begin
        state_nxt = hit ? ST_REPLY : ST_ITEM_RD;
      end
      ST_REPLY: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    node_we  = 1'b0;
    item_we  = 1'b0;
    out_load = 1'b0;
    out_res  = RES_ACK;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop    = 1'b1;
          node_we  = (q_cmd.op == OP_NODE_WR);
          item_we  = (q_cmd.op == OP_ITEM_WR);
          out_load = (q_cmd.op != OP_QUERY);
        end
      end
      ST_REPLY: begin
        out_load = slot_free;
        out_res  = res_r;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (out_load)       out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else                out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res_r <= out_res;
    unique case (state_r)
      ST_IDLE: begin
        x_r      <= q_coord[0];
        y_r      <= q_coord[1];
        cur_r    <= '0;
        visits_r <= '0;
      end
      ST_NODE_EVAL: begin
        if (!is_split) begin
          ptr_r <= PTR_BITS'(nd_first);
          end_r <= PTR_BITS'(nd_first) + PTR_BITS'(nd_second);
        end else if (link_bad || long_walk) begin
          res_r <= '{is_answer: 1'b1, found: 1'b0, rect: '0, walk_fault: 1'b1};
        end else begin
          cur_r    <= next_addr;
          visits_r <= visits_r + NA'(1);
        end
      end
      ST_ITEM_RD: begin
        if (!item_ok) res_r <= '{is_answer: 1'b1, found: 1'b0, rect: '0, walk_fault: 1'b0};
      end
      ST_ITEM_EVAL: begin
        if (hit) res_r <= '{is_answer: 1'b1, found: 1'b1, rect: it_owner, walk_fault: 1'b0};
        else     ptr_r <= ptr_r + PTR_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_is_answer  = out_res_r.is_answer;
  assign out_found      = out_res_r.found;
  assign out_found_rect = out_res_r.rect;
  assign out_walk_fault = out_res_r.walk_fault;

endmodule

`default_nettype wire

FILE: src/rect_bsp_point_lookup_top.sv
// Top level of the rectangle BSP point lookup block: joins the front end,
// its command queue and the back end. Depends on rbpl_pkg, rbpl_front, rbpl_back.
//
//   channel  direction  handshake             payload
//   in_*     input      in_valid / in_stall   command, index, node, item, point
//   out_*    output     out_valid / out_stall answer, found, rectangle, fault
//
// A write transaction is performed in the back end as it leaves the queue. A query
// leaves the queue, then reads and evaluates each node visited, reads and tests each
// leaf item scanned, takes an extra item read when the scan ends without a hit, and
// loads the result; the node and item memories have registered reads.
// Reset is synchronous and clears control state only; table contents are
// undefined until written. The two-entry queue keeps accepting until it holds
// two transactions while the back end works or the result register is stalled.
`default_nettype none

module rect_bsp_point_lookup_top #(
  parameter int NODE_DEPTH = 1024,
  parameter int ITEM_DEPTH = 2048,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rbpl_pkg::CMD_BITS-1:0]       in_command,
  input  wire logic [rbpl_pkg::IDX_BITS-1:0]       in_entry_index,
  input  wire logic [rbpl_pkg::KIND_BITS-1:0]      in_node_kind,
  input  wire logic [rbpl_pkg::IDX_BITS-1:0]       in_first_link,
  input  wire logic [rbpl_pkg::LINK2_BITS-1:0]     in_second_link,
  input  wire logic [rbpl_pkg::RECT_BITS-1:0]      in_rect_id,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_left,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_top,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_right,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_bottom,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_is_answer,
  output logic                                     out_found,
  output logic [rbpl_pkg::RECT_BITS-1:0]           out_found_rect,
  output logic                                     out_walk_fault
);
  import rbpl_pkg::*;

  logic                        q_valid;
  cmd_t                        q_cmd;
  logic [3:0][COORD_BITS-1:0]  q_coord;
  logic                        q_pop;

  rbpl_front #(
    .NODE_DEPTH (NODE_DEPTH),
    .ITEM_DEPTH (ITEM_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_index  (in_entry_index),
    .in_node_kind    (in_node_kind),
    .in_first_link   (in_first_link),
    .in_second_link  (in_second_link),
    .in_rect_id      (in_rect_id),
    .in_coord_left   (in_coord_left),
    .in_coord_top    (in_coord_top),
    .in_coord_right  (in_coord_right),
    .in_coord_bottom (in_coord_bottom),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_coord         (q_coord),
    .q_pop           (q_pop)
  );

  rbpl_back #(
    .NODE_DEPTH (NODE_DEPTH),
    .ITEM_DEPTH (ITEM_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_coord        (q_coord),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_answer  (out_is_answer),
    .out_found      (out_found),
    .out_found_rect (out_found_rect),
    .out_walk_fault (out_walk_fault)
  );

endmodule

`default_nettype wire

FILE: src/rbpl_checker.sv
// Port-level checks on the result channel of the lookup block, and the bind
// that attaches them to rect_bsp_point_lookup_top. Depends on rbpl_pkg.
`default_nettype none

module rbpl_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_is_answer,
  input wire logic                          out_found,
  input wire logic [rbpl_pkg::RECT_BITS-1:0] out_found_rect,
  input wire logic                          out_walk_fault
);

  a_reset_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_answer) && $stable(out_found)
      && $stable(out_found_rect) && $stable(out_walk_fault))
    else $error("stalled result transaction changed");

  a_ack_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_answer |-> !out_found && !out_walk_fault && (out_found_rect == '0))
    else $error("write acknowledge carries answer fields");

  a_found_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_walk_fault)
    else $error("found and walk fault both set");

  a_miss_has_no_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_found_rect == '0))
    else $error("rectangle identity without a hit");

endmodule

bind rect_bsp_point_lookup_top rbpl_checker u_rbpl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_is_answer  (out_is_answer),
  .out_found      (out_found),
  .out_found_rect (out_found_rect),
  .out_walk_fault (out_walk_fault)
);

`default_nettype wire
